/* design/fla_pkg.sv */
// Shared constants for the free list allocator.
`default_nettype none
package fla_pkg;
  localparam int MAX_BLOCKS_DEF = 16;
  localparam int ADDR_BITS_DEF  = 16;
  localparam logic [1:0] ST_ALLOC = 2'd0;
  localparam logic [1:0] ST_FREED = 2'd1;
  localparam logic [1:0] ST_NOFIT = 2'd2;
  localparam logic [1:0] ST_ERROR = 2'd3;
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;
  localparam logic [1:0] POL_SPARE = 2'd3;
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;
endpackage
`default_nettype wire

/* design/free_list_allocator_top.sv */
// Free list allocator: sorted table of free blocks held in one synchronous memory.
// Flow: a scan over the n stored entries, then up to n shift moves of a read and a write,
// then one result strobe; one request at a time.
// The memory read port (one entry per read, registered output) paces the scan and shifts.
// Reset (synchronous, rst high) empties the table and clears fit_policy; no clearing pass.
// Results show for one cycle on done; the receiver cannot stall.
`default_nettype none
module free_list_allocator_top #(
  parameter int MAX_BLOCKS = fla_pkg::MAX_BLOCKS_DEF,
  parameter int ADDR_BITS  = fla_pkg::ADDR_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 req_type,
  input  wire logic [ADDR_BITS:0]   req_size,
  input  wire logic [ADDR_BITS-1:0] free_address,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_wdata,
  output logic                      done,
  output logic [1:0]                status,
  output logic [ADDR_BITS-1:0]      alloc_address,
  output logic [$clog2(MAX_BLOCKS+1)-1:0] block_count
);
  import fla_pkg::*;
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS+1);
  localparam int EW = 2*ADDR_BITS+1;
  localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

  localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_DEC = 3'd2,
                         S_RD = 3'd3, S_WR = 3'd4, S_DONE = 3'd5;

  logic [EW-1:0] mem [MAX_BLOCKS];
  logic [EW-1:0] rdata;
  logic          mre, mwe;
  logic [IW-1:0] raddr, waddr;
  logic [EW-1:0] wdata;
  always_ff @(posedge clk) begin
    if (mwe) mem[waddr] <= wdata;
    if (mre) rdata <= mem[raddr];
  end

  logic [2:0] state;
  logic [1:0] fit_policy;
  logic [CW-1:0] count, idx, pick, k, kend;
  logic rvalid, found, kind, shift_up;
  logic [ADDR_BITS:0] size, plen, prev_len;
  logic [ADDR_BITS-1:0] addr, pstart, prev_start;
  logic [1:0] res_status;
  logic [ADDR_BITS-1:0] res_addr;
  logic [CW-1:0] pos;
  logic [EW-1:0] ins_word;

  wire [ADDR_BITS-1:0] rs = rdata[EW-1:ADDR_BITS+1];
  wire [ADDR_BITS:0]   rl = rdata[ADDR_BITS:0];
  wire [ADDR_BITS+1:0] prev_end = {2'b0, prev_start} + {1'b0, prev_len};
  wire [ADDR_BITS+1:0] free_end = {2'b0, addr} + {1'b0, size};
  wire [ADDR_BITS:0]   merge_len = prev_len + size;
  wire prev_hit  = (pos != '0) && (prev_end == {2'b0, addr});
  wire next_hit  = (pos < count) && (free_end == {2'b0, pstart});
  wire range_bad = (size == '0) || (free_end > {2'b01, {ADDR_BITS{1'b0}}});

  assign busy = (state != S_IDLE);

  always_comb begin
    mre = 1'b0; raddr = idx[IW-1:0];
    mwe = 1'b0; waddr = pick[IW-1:0]; wdata = '0;
    if (state == S_SCAN && !rvalid && idx < count) mre = 1'b1;
    if (state == S_DEC) begin
      if (kind == REQ_ALLOC) begin
        if (found && plen != size) begin
          mwe = 1'b1; waddr = pick[IW-1:0];
          wdata = {pstart + size[ADDR_BITS-1:0], plen - size};
        end
      end else if (!range_bad) begin
        if (prev_hit) begin
          mwe = 1'b1; waddr = IW'(pos - 1'b1);
          wdata = {prev_start, next_hit ? merge_len + plen : merge_len};
        end else if (next_hit) begin
          mwe = 1'b1; waddr = pos[IW-1:0]; wdata = {addr, plen + size};
        end
      end
    end
    if (state == S_RD) begin
      mre = 1'b1; raddr = shift_up ? IW'(k - 1'b1) : IW'(k + 1'b1);
      if (k == kend && shift_up) begin
        mwe = 1'b1; waddr = k[IW-1:0]; wdata = ins_word;
      end
    end
    if (state == S_WR) begin
      mwe = 1'b1; waddr = k[IW-1:0]; wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; count <= '0; fit_policy <= POL_FIRST;
      rvalid <= 1'b0; done <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      if (cfg_we) fit_policy <= cfg_wdata;
      unique case (state)
        S_IDLE: if (start) begin
          kind <= req_type; size <= req_size; addr <= free_address;
          idx <= '0; rvalid <= 1'b0; found <= 1'b0;
          pos <= count; prev_len <= '0; prev_start <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (!rvalid) begin
            if (idx < count) rvalid <= 1'b1;
            else state <= S_DEC;
          end else begin
            rvalid <= 1'b0; idx <= idx + 1'b1;
            if (kind == REQ_ALLOC) begin
              if (rl >= size) begin
                if (!found || (fit_policy == POL_BEST && rl < plen) ||
                    (fit_policy == POL_WORST && rl > plen)) begin
                  pick <= idx; pstart <= rs; plen <= rl;
                end
                found <= 1'b1;
                if (!found && fit_policy != POL_BEST && fit_policy != POL_WORST)
                  state <= S_DEC;
              end
            end else begin
              if (rs < addr) begin
                prev_start <= rs; prev_len <= rl;
              end else begin
                pos <= idx; pstart <= rs; plen <= rl; state <= S_DEC;
              end
            end
          end
        end
        S_DEC: begin
          res_addr <= (kind == REQ_ALLOC && found) ? pstart : '0;
          if (kind == REQ_ALLOC) begin
            res_status <= found ? ST_ALLOC : ST_NOFIT;
            if (found && plen == size) begin
              k <= pick; kend <= count - 1'b1; shift_up <= 1'b0;
              count <= count - 1'b1; state <= S_RD;
            end else state <= S_DONE;
          end else if (range_bad) begin
            res_status <= ST_ERROR; state <= S_DONE;
          end else if (prev_hit && next_hit) begin
            // both neighbors absorbed: drop the following entry
            res_status <= ST_FREED;
            k <= pos; kend <= count - 1'b1; shift_up <= 1'b0;
            count <= count - 1'b1; state <= S_RD;
          end else if (prev_hit || next_hit) begin
            res_status <= ST_FREED; state <= S_DONE;
          end else if (count >= MAXC) begin
            res_status <= ST_ERROR; state <= S_DONE;
          end else begin
            res_status <= ST_FREED; ins_word <= {addr, size};
            k <= count; kend <= pos; shift_up <= 1'b1;
            count <= count + 1'b1; state <= S_RD;
          end
        end
        S_RD: begin
          if (k == kend) state <= S_DONE;
          else state <= S_WR;
        end
        S_WR: begin
          k <= shift_up ? k - 1'b1 : k + 1'b1;
          state <= S_RD;
        end
        S_DONE: begin
          status <= res_status; alloc_address <= res_addr;
          block_count <= count; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* design/fla_checker.sv */
// Port-level checker for the free list allocator, bound to the top level.
`default_nettype none
module fla_checker #(
  parameter int ADDR_BITS = fla_pkg::ADDR_BITS_DEF,
  parameter int CW = 5
) (
  input wire logic clk, rst, start, busy, done,
  input wire logic [1:0] status,
  input wire logic [ADDR_BITS-1:0] alloc_address,
  input wire logic [CW-1:0] block_count
);
  import fla_pkg::*;
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accept did not raise busy");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result held two cycles");
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_ALLOC |-> alloc_address == '0) else $error("address without grant");
endmodule
bind free_list_allocator_top fla_checker #(.ADDR_BITS(ADDR_BITS),
  .CW($clog2(MAX_BLOCKS+1))) u_chk (.*);
`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the free list allocator: scoreboard, request driver, checks.
`default_nettype none
module testbench;
  import fla_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] addr;
    logic [4:0]  count;
  } alloc_word_t;

  class alloc_scoreboard;
    longint      blk_start[MAX_BLOCKS_DEF];
    longint      blk_len[MAX_BLOCKS_DEF];
    int          n_entries;
    logic [1:0]  policy;
    alloc_word_t pending_q[$];
    int          errors;

    function new();
      n_entries = 0;
      policy    = POL_FIRST;
      errors    = 0;
    endfunction

    function void remove_at(int pos);
      for (int k = pos; k + 1 < n_entries; k++) begin
        blk_start[k] = blk_start[k + 1];
        blk_len[k]   = blk_len[k + 1];
      end
      n_entries--;
    endfunction

    function void insert_at(int pos, longint s, longint l);
      for (int k = n_entries; k > pos; k--) begin
        blk_start[k] = blk_start[k - 1];
        blk_len[k]   = blk_len[k - 1];
      end
      blk_start[pos] = s;
      blk_len[pos]   = l;
      n_entries++;
    endfunction

    // Apply one accepted request to the table copy and queue its result.
    function alloc_word_t note(logic kind, logic [16:0] size, logic [15:0] faddr);
      alloc_word_t w;
      bit          found;
      int          pick;
      int          pos;
      longint      sz;
      longint      a;
      sz = size;
      a = faddr;
      w.addr = '0;
      if (kind == REQ_ALLOC) begin
        found = 0;
        pick = 0;
        for (int i = 0; i < n_entries; i++) begin
          if (blk_len[i] < sz) continue;
          if (!found) begin
            found = 1;
            pick = i;
            if (policy != POL_BEST && policy != POL_WORST) break;
          end else if (policy == POL_BEST && blk_len[i] < blk_len[pick]) begin
            pick = i;
          end else if (policy == POL_WORST && blk_len[i] > blk_len[pick]) begin
            pick = i;
          end
        end
        if (!found) begin
          w.status = ST_NOFIT;
        end else begin
          w.status = ST_ALLOC;
          w.addr = blk_start[pick][15:0];
          blk_start[pick] += sz;
          blk_len[pick] -= sz;
          if (blk_len[pick] == 0) remove_at(pick);
        end
      end else if (sz == 0 || a + sz > 65536) begin
        w.status = ST_ERROR;
      end else begin
        pos = 0;
        while (pos < n_entries && blk_start[pos] < a) pos++;
        w.status = ST_FREED;
        if (pos > 0 && blk_start[pos - 1] + blk_len[pos - 1] == a) begin
          blk_len[pos - 1] += sz;
          if (pos < n_entries && blk_start[pos - 1] + blk_len[pos - 1] == blk_start[pos]) begin
            blk_len[pos - 1] += blk_len[pos];
            remove_at(pos);
          end
        end else if (pos < n_entries && a + sz == blk_start[pos]) begin
          blk_start[pos] = a;
          blk_len[pos] += sz;
        end else if (n_entries >= MAX_BLOCKS_DEF) begin
          w.status = ST_ERROR;
        end else begin
          insert_at(pos, a, sz);
        end
      end
      w.count = n_entries[4:0];
      pending_q.push_back(w);
      return w;
    endfunction

    function void check(logic [1:0] st, logic [15:0] ad, logic [4:0] cnt);
      alloc_word_t w;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result status %0d addr %0d count %0d", $time, st, ad, cnt);
        errors++;
        return;
      end
      w = pending_q.pop_front();
      if (st !== w.status) begin
        $display("%0t: status expected %0d actual %0d", $time, w.status, st);
        errors++;
      end
      if (ad !== w.addr) begin
        $display("%0t: alloc_address expected %0d actual %0d", $time, w.addr, ad);
        errors++;
      end
      if (cnt !== w.count) begin
        $display("%0t: block_count expected %0d actual %0d", $time, w.count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        req_type = REQ_ALLOC;
  logic [16:0] req_size = '0;
  logic [15:0] free_address = '0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_wdata = '0;
  logic        done;
  logic [1:0]  status;
  logic [15:0] alloc_address;
  logic [4:0]  block_count;

  alloc_scoreboard sb = new();
  int          cycle_count = 0;
  int          idle_pct = 0;
  logic [15:0] held_addr[$];
  logic [16:0] held_size[$];

  free_list_allocator_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .req_size(req_size), .free_address(free_address),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .done(done), .status(status), .alloc_address(alloc_address),
    .block_count(block_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (done) sb.check(status, alloc_address, block_count);
    if (cycle_count > 3000000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Present one word and hold it until accepted; track granted regions for freeing back.
  task automatic send_req(logic kind, logic [16:0] size, logic [15:0] faddr);
    alloc_word_t w;
    start        <= 1'b1;
    req_type     <= kind;
    req_size     <= size;
    free_address <= faddr;
    @(posedge clk);
    while (busy) @(posedge clk);
    w = sb.note(kind, size, faddr);
    if (kind == REQ_ALLOC && w.status == ST_ALLOC && size != 0) begin
      held_addr.push_back(w.addr);
      held_size.push_back(size);
    end
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_policy(logic [1:0] pol);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= pol;
    @(posedge clk);
    sb.policy = pol;
    cfg_we <= 1'b0;
  endtask

  task automatic random_req();
    int r;
    int j;
    logic [16:0] sz;
    r = $urandom_range(99);
    if (r < 12) begin
      // noise: arbitrary fields, often overlapping or out of range
      send_req(1'($urandom_range(1)), 17'($urandom_range(65536)), 16'($urandom));
    end else if (r < 17) begin
      send_req(REQ_FREE, 17'($urandom_range(1, 300)), 16'($urandom));
    end else if (r < 55 && held_addr.size() != 0) begin
      j = int'($urandom_range(held_addr.size() - 1));
      send_req(REQ_FREE, held_size[j], held_addr[j]);
      held_addr.delete(j);
      held_size.delete(j);
    end else begin
      r = $urandom_range(99);
      if (r < 3) sz = 0;
      else if (r < 80) sz = 17'($urandom_range(1, 64));
      else sz = 17'($urandom_range(65, 4096));
      send_req(REQ_ALLOC, sz, 16'($urandom));
    end
  endtask

  initial begin
    int idle_tab[4];
    logic [1:0] pol_tab[4];
    idle_tab = '{0, 63, 0, 26};
    pol_tab  = '{POL_BEST, POL_WORST, POL_SPARE, POL_FIRST};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, zero and oversize frees, whole space, merges, full table
    send_req(REQ_ALLOC, 17'd0, 16'd0);
    send_req(REQ_FREE, 17'd0, 16'd100);
    send_req(REQ_FREE, 17'd2, 16'hFFFF);
    send_req(REQ_FREE, 17'd65536, 16'd0);
    send_req(REQ_ALLOC, 17'd65536, 16'hFFFF);
    send_req(REQ_FREE, 17'd100, 16'd1000);
    send_req(REQ_FREE, 17'd50, 16'd2000);
    send_req(REQ_FREE, 17'd100, 16'd1100);
    send_req(REQ_FREE, 17'd100, 16'd1900);
    send_req(REQ_FREE, 17'd700, 16'd1200);
    send_req(REQ_ALLOC, 17'd0, 16'd0);
    send_req(REQ_ALLOC, 17'd60000, 16'd0);
    send_req(REQ_FREE, 17'd1, 16'hFFFF);
    for (int k = 0; k < 16; k++) send_req(REQ_FREE, 17'd10, 16'(10000 + k * 100));
    send_req(REQ_FREE, 17'd10, 16'd10090);
    send_req(REQ_ALLOC, 17'd16, 16'd0);

    for (int ph = 0; ph < 8; ph++) begin
      write_policy(pol_tab[(ph + ph / 4) % 4]);
      idle_pct = idle_tab[ph % 4];
      for (int n = 0; n < 128; n++) begin
        if (ph == 3 && n == 64) drain();
        random_req();
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
design/fla_pkg.sv
design/free_list_allocator_top.sv
design/fla_checker.sv
tb/sv/testbench.sv
